[hw/rtl/hmd_pkg.sv]
// shared types, constants and arctangent table for the haversine move detector
package hmd_pkg;

  // fixed-point constants
  localparam logic [29:0] INV_GAIN_Q30 = 30'd652032874;
  localparam logic [26:0] DEG2RAD_Q32  = 27'd74961321;
  localparam logic [12:0] EARTH_KM     = 13'd6371;
  localparam logic [22:0] DIST_MAX     = 23'd5124000;
  localparam logic [22:0] THRESH_RESET = 23'd1280;
  localparam logic [4:0]  SQRT_LAST    = 5'd30;

  // datapath word widths
  localparam int CR_W  = 35;
  localparam int MUL_W = 33;

  // controller states, one-hot
  typedef enum logic [10:0] {
    S_IDLE = 11'b000_0000_0001,
    S_WRAP = 11'b000_0000_0010,
    S_FIX  = 11'b000_0000_0100,
    S_FOLD = 11'b000_0000_1000,
    S_RAD  = 11'b000_0001_0000,
    S_ROT  = 11'b000_0010_0000,
    S_PROD = 11'b000_0100_0000,
    S_SQRT = 11'b000_1000_0000,
    S_ATAN = 11'b001_0000_0000,
    S_DIST = 11'b010_0000_0000,
    S_DONE = 11'b100_0000_0000
  } ctrl_state_t;

  typedef enum logic [1:0] {
    PH_LOAD = 2'd0,
    PH_RUN  = 2'd1,
    PH_SAVE = 2'd2
  } phase_t;

  typedef enum logic [2:0] {
    MUL_RAD  = 3'd0,
    MUL_S1   = 3'd1,
    MUL_C12  = 3'd2,
    MUL_S2   = 3'd3,
    MUL_A    = 3'd4,
    MUL_DIST = 3'd5
  } mul_op_t;

  // controller to datapath commands
  typedef struct packed {
    logic       capture;
    logic [1:0] job;
    logic [4:0] step;
    logic       wr_load;
    logic       wr_step;
    logic       wr_fix;
    logic       wr_fold;
    logic       mul_go;
    logic       mul_save;
    mul_op_t    mul_op;
    logic       cr_load;
    logic       cr_step;
    logic       cr_save;
    logic       cr_vec;
    logic       sq_load;
    logic       sq_step;
    logic       sq_save;
    logic       commit;
  } dp_cmd_t;

  // truncated arctangent of 2^-i, Q30
  function automatic logic [29:0] atan_q30(input logic [4:0] i);
    logic [29:0] v;
    case (i)
      5'd0:  v = 30'd843314856;
      5'd1:  v = 30'd497837829;
      5'd2:  v = 30'd263043836;
      5'd3:  v = 30'd133525158;
      5'd4:  v = 30'd67021686;
      5'd5:  v = 30'd33543515;
      5'd6:  v = 30'd16775850;
      5'd7:  v = 30'd8388437;
      5'd8:  v = 30'd4194282;
      5'd9:  v = 30'd2097149;
      5'd10: v = 30'd1048575;
      5'd11: v = 30'd524287;
      5'd12: v = 30'd262143;
      5'd13: v = 30'd131071;
      5'd14: v = 30'd65535;
      5'd15: v = 30'd32767;
      5'd16: v = 30'd16383;
      5'd17: v = 30'd8191;
      5'd18: v = 30'd4095;
      5'd19: v = 30'd2047;
      5'd20: v = 30'd1023;
      5'd21: v = 30'd511;
      5'd22: v = 30'd255;
      5'd23: v = 30'd127;
      5'd24: v = 30'd63;
      5'd25: v = 30'd31;
      5'd26: v = 30'd15;
      5'd27: v = 30'd7;
      5'd28: v = 30'd3;
      5'd29: v = 30'd1;
      default: v = 30'd0;
    endcase
    return v;
  endfunction

endpackage

[hw/rtl/hmd_ctrl.sv]
// sequencing state machine for the haversine move detector
module hmd_ctrl
  import hmd_pkg::*;
#(
  parameter int ANGLE_FRAC_BITS   = 20,
  parameter int CORDIC_ITERATIONS = 24
) (
  input  logic    clk,
  input  logic    rst,
  input  logic    in_valid,
  output logic    in_ready,
  output logic    out_valid,
  input  logic    out_ready,
  input  logic    pos_valid,
  output dp_cmd_t cmd
);

  // highest shift of the modulus in the remainder loop
  localparam int WrapTop = (ANGLE_FRAC_BITS >= 21) ? 0 : 21 - ANGLE_FRAC_BITS;
  localparam logic [4:0] WrapStart = 5'(WrapTop);
  localparam logic [4:0] CrLast    = 5'(CORDIC_ITERATIONS - 1);

  ctrl_state_t state, state_next;
  phase_t      phase, phase_next;
  logic [1:0]  job, job_next;
  logic [4:0]  step, step_next;
  logic        out_valid_next;

  // next state and command decode
  always_comb begin
    state_next = state;
    phase_next = phase;
    job_next   = job;
    step_next  = step;
    cmd        = '0;
    cmd.job    = job;
    cmd.step   = step;
    cmd.mul_op = MUL_RAD;
    in_ready   = 1'b0;
    out_valid_next = out_valid && !out_ready;
    unique case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.capture = 1'b1;
          job_next    = 2'd0;
          phase_next  = PH_LOAD;
          state_next  = pos_valid ? S_WRAP : S_DONE;
        end
      end
      S_WRAP: begin
        if (phase == PH_LOAD) begin
          cmd.wr_load = 1'b1;
          step_next   = WrapStart;
          phase_next  = PH_RUN;
        end else begin
          cmd.wr_step = 1'b1;
          if (step == 5'd0) begin
            state_next = S_FIX;
          end else begin
            step_next = step - 5'd1;
          end
        end
      end
      S_FIX: begin
        cmd.wr_fix = 1'b1;
        state_next = S_FOLD;
      end
      S_FOLD: begin
        cmd.wr_fold = 1'b1;
        phase_next  = PH_LOAD;
        job_next    = job + 2'd1;
        state_next  = (job == 2'd3) ? S_RAD : S_WRAP;
      end
      S_RAD: begin
        cmd.mul_op = MUL_RAD;
        if (phase == PH_LOAD) begin
          cmd.mul_go = 1'b1;
          phase_next = PH_RUN;
        end else begin
          cmd.mul_save = 1'b1;
          phase_next   = PH_LOAD;
          job_next     = job + 2'd1;
          if (job == 2'd3) begin
            state_next = S_ROT;
          end
        end
      end
      S_ROT: begin
        unique case (phase)
          PH_LOAD: begin
            cmd.cr_load = 1'b1;
            step_next   = 5'd0;
            phase_next  = PH_RUN;
          end
          PH_RUN: begin
            cmd.cr_step = 1'b1;
            if (step == CrLast) begin
              phase_next = PH_SAVE;
            end else begin
              step_next = step + 5'd1;
            end
          end
          default: begin
            cmd.cr_save = 1'b1;
            phase_next  = PH_LOAD;
            job_next    = job + 2'd1;
            if (job == 2'd3) begin
              state_next = S_PROD;
            end
          end
        endcase
      end
      S_PROD: begin
        unique case (job)
          2'd0:    cmd.mul_op = MUL_S1;
          2'd1:    cmd.mul_op = MUL_C12;
          2'd2:    cmd.mul_op = MUL_S2;
          default: cmd.mul_op = MUL_A;
        endcase
        if (phase == PH_LOAD) begin
          cmd.mul_go = 1'b1;
          phase_next = PH_RUN;
        end else begin
          cmd.mul_save = 1'b1;
          phase_next   = PH_LOAD;
          job_next     = job + 2'd1;
          if (job == 2'd3) begin
            state_next = S_SQRT;
          end
        end
      end
      S_SQRT: begin
        unique case (phase)
          PH_LOAD: begin
            cmd.sq_load = 1'b1;
            step_next   = 5'd0;
            phase_next  = PH_RUN;
          end
          PH_RUN: begin
            cmd.sq_step = 1'b1;
            if (step == SQRT_LAST) begin
              phase_next = PH_SAVE;
            end else begin
              step_next = step + 5'd1;
            end
          end
          default: begin
            cmd.sq_save = 1'b1;
            phase_next  = PH_LOAD;
            if (job == 2'd1) begin
              job_next   = 2'd0;
              state_next = S_ATAN;
            end else begin
              job_next = job + 2'd1;
            end
          end
        endcase
      end
      S_ATAN: begin
        cmd.cr_vec = 1'b1;
        if (phase == PH_LOAD) begin
          cmd.cr_load = 1'b1;
          step_next   = 5'd0;
          phase_next  = PH_RUN;
        end else begin
          cmd.cr_step = 1'b1;
          if (step == CrLast) begin
            phase_next = PH_LOAD;
            state_next = S_DIST;
          end else begin
            step_next = step + 5'd1;
          end
        end
      end
      S_DIST: begin
        cmd.mul_op = MUL_DIST;
        if (phase == PH_LOAD) begin
          cmd.mul_go = 1'b1;
          phase_next = PH_RUN;
        end else begin
          cmd.mul_save = 1'b1;
          state_next   = S_DONE;
        end
      end
      S_DONE: begin
        if (!out_valid || out_ready) begin
          cmd.commit     = 1'b1;
          out_valid_next = 1'b1;
          state_next     = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      phase     <= PH_LOAD;
      job       <= 2'd0;
      step      <= 5'd0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      phase     <= phase_next;
      job       <= job_next;
      step      <= step_next;
      out_valid <= out_valid_next;
    end
  end

`ifndef SYNTH
  a_first_skips: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE && in_valid && !pos_valid) |=> state == S_DONE)
    else $error("first fix did not go straight to result");
  a_commit_shows: assert property (@(posedge clk) disable iff (rst)
    cmd.commit |=> out_valid)
    else $error("committed word not presented");
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |-> !cmd.commit)
    else $error("result overwritten while waiting");
`endif

endmodule

[hw/rtl/hmd_datapath.sv]
// wrap, multiply, cordic and square root datapath of the haversine move detector
module hmd_datapath
  import hmd_pkg::*;
#(
  parameter int ANGLE_FRAC_BITS = 20
) (
  input  logic               clk,
  input  logic               rst,
  input  dp_cmd_t            cmd,
  input  logic               cfg_valid,
  input  logic [22:0]        cfg_data,
  input  logic signed [27:0] new_latitude,
  input  logic signed [28:0] new_longitude,
  output logic               pos_valid,
  output logic               moved,
  output logic               first_fix,
  output logic [22:0]        distance_q8
);

  localparam int F  = ANGLE_FRAC_BITS;
  localparam int AW = F + 8;
  localparam logic [33:0] WrapMod = 34'(360) << F;
  localparam logic [33:0] Half    = 34'(180) << F;
  localparam logic [33:0] Quarter = 34'(90) << F;
  localparam logic signed [65:0] RndHalf = 66'sd1 << (F + 2);
  localparam logic signed [65:0] RndCos  = 66'sd1 << (F + 1);
  localparam logic signed [65:0] RndDist = 66'sd1 << 20;
  localparam logic [61:0] OneQ30 = 62'd1 << 30;

  logic [22:0]        thr;
  logic signed [27:0] pos_lat, lat2;
  logic signed [28:0] pos_lon, lon2;
  logic               first_r;
  logic [22:0]        dist_r;

  logic [33:0]        wr_r;
  logic               wr_neg;
  logic [AW-1:0]      ang [4];
  logic               cneg [4];
  logic signed [31:0] zq [4];
  logic signed [32:0] res [4];

  logic signed [MUL_W-1:0]   ma, mb;
  logic signed [2*MUL_W-1:0] mp;
  logic signed [32:0]        t0, t1, t2;
  logic [30:0]               a_r;

  logic signed [CR_W-1:0] cr_x, cr_y, cr_z;
  logic [61:0]            sq_v, sq_r;
  logic [30:0]            sq_p, sq_q;

  // wrap operand selection
  logic signed [30:0] wv, wmag;
  logic [33:0]        wmod_k, wfold, wl;
  logic               wcneg;
  always_comb begin
    unique case (cmd.job)
      2'd0:    wv = 31'(lat2) - 31'(pos_lat);
      2'd1:    wv = 31'(lon2) - 31'(pos_lon);
      2'd2:    wv = 31'(pos_lat);
      default: wv = 31'(lat2);
    endcase
    wmag   = wv[30] ? -wv : wv;
    wmod_k = WrapMod << cmd.step;
    wfold  = (wr_r > Half) ? WrapMod - wr_r : wr_r;
    wcneg  = cmd.job[1] && (wfold > Quarter);
    wl     = wcneg ? Half - wfold : wfold;
  end

  // multiplier operand selection
  logic signed [CR_W-1:0] zpos;
  always_comb begin
    zpos = (cr_z < 0) ? '0 : cr_z;
    case (cmd.mul_op)
      MUL_RAD: begin
        ma = MUL_W'(ang[cmd.job]);
        mb = MUL_W'(DEG2RAD_Q32);
      end
      MUL_S1: begin
        ma = res[0];
        mb = res[0];
      end
      MUL_C12: begin
        ma = res[2];
        mb = res[3];
      end
      MUL_S2: begin
        ma = res[1];
        mb = res[1];
      end
      MUL_A: begin
        ma = t1;
        mb = t2;
      end
      default: begin
        ma = MUL_W'(zpos);
        mb = MUL_W'(EARTH_KM);
      end
    endcase
  end

  // product post-processing
  logic signed [65:0] rad_h, rad_c, dsh;
  logic signed [34:0] asum;
  always_comb begin
    rad_h = (mp + RndHalf) >>> (F + 3);
    rad_c = (mp + RndCos) >>> (F + 2);
    dsh   = (mp + RndDist) >>> 21;
    asum  = 35'(t0) + 35'(mp >>> 30);
  end

  // cordic micro-rotation
  logic signed [CR_W-1:0] sx, sy, at;
  logic                   cdir;
  always_comb begin
    sx   = cr_x >>> cmd.step;
    sy   = cr_y >>> cmd.step;
    at   = CR_W'(atan_q30(cmd.step));
    cdir = cmd.cr_vec ? (cr_y >= 0) : (cr_z >= 0);
  end

  // square root step
  logic [61:0] sb, stry;
  always_comb begin
    sb   = 62'd1 << {5'd30 - cmd.step, 1'b0};
    stry = sq_r + sb;
  end

  // control state: threshold and stored position
  always_ff @(posedge clk) begin
    if (rst) begin
      thr       <= THRESH_RESET;
      pos_valid <= 1'b0;
      pos_lat   <= '0;
      pos_lon   <= '0;
    end else begin
      if (cfg_valid) begin
        thr <= cfg_data;
      end
      if (cmd.commit && (first_r || dist_r >= thr)) begin
        pos_valid <= 1'b1;
        pos_lat   <= lat2;
        pos_lon   <= lon2;
      end
    end
  end

  // working registers
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      lat2    <= new_latitude;
      lon2    <= new_longitude;
      first_r <= !pos_valid;
      dist_r  <= '0;
    end
    // angle wrapping
    if (cmd.wr_load) begin
      wr_neg <= wv[30];
      wr_r   <= 34'($unsigned(wmag));
    end
    if (cmd.wr_step && wr_r >= wmod_k) begin
      wr_r <= wr_r - wmod_k;
    end
    if (cmd.wr_fix && wr_neg && wr_r != '0) begin
      wr_r <= WrapMod - wr_r;
    end
    if (cmd.wr_fold) begin
      ang[cmd.job]  <= wl[AW-1:0];
      cneg[cmd.job] <= wcneg;
    end
    // shared multiplier
    if (cmd.mul_go) begin
      mp <= ma * mb;
    end
    if (cmd.mul_save) begin
      case (cmd.mul_op)
        MUL_RAD:  zq[cmd.job] <= cmd.job[1] ? 32'(rad_c) : 32'(rad_h);
        MUL_S1:   t0 <= 33'(mp >>> 30);
        MUL_C12:  t1 <= 33'(mp >>> 30);
        MUL_S2:   t2 <= 33'(mp >>> 30);
        MUL_A: begin
          if (asum < 0) begin
            a_r <= '0;
          end else if (asum > 35'sd1073741824) begin
            a_r <= 31'd1073741824;
          end else begin
            a_r <= 31'(asum);
          end
        end
        default: dist_r <= (dsh > 66'(DIST_MAX)) ? DIST_MAX : 23'(dsh);
      endcase
    end
    // shared cordic
    if (cmd.cr_load) begin
      if (cmd.cr_vec) begin
        cr_x <= CR_W'(sq_q);
        cr_y <= CR_W'(sq_p);
        cr_z <= '0;
      end else begin
        cr_x <= CR_W'(INV_GAIN_Q30);
        cr_y <= '0;
        cr_z <= CR_W'(zq[cmd.job]);
      end
    end
    if (cmd.cr_step) begin
      if (cmd.cr_vec == cdir) begin
        cr_x <= cr_x + sy;
        cr_y <= cr_y - sx;
      end else begin
        cr_x <= cr_x - sy;
        cr_y <= cr_y + sx;
      end
      if (cdir) begin
        cr_z <= cmd.cr_vec ? cr_z + at : cr_z - at;
      end else begin
        cr_z <= cmd.cr_vec ? cr_z - at : cr_z + at;
      end
    end
    if (cmd.cr_save) begin
      if (!cmd.job[1]) begin
        res[cmd.job] <= 33'(cr_y);
      end else begin
        res[cmd.job] <= cneg[cmd.job] ? 33'(-cr_x) : 33'(cr_x);
      end
    end
    // shared square root
    if (cmd.sq_load) begin
      sq_r <= '0;
      sq_v <= cmd.job[0] ? ((OneQ30 - 62'(a_r)) << 30) : (62'(a_r) << 30);
    end
    if (cmd.sq_step) begin
      if (sq_v >= stry) begin
        sq_v <= sq_v - stry;
        sq_r <= (sq_r >> 1) + sb;
      end else begin
        sq_r <= sq_r >> 1;
      end
    end
    if (cmd.sq_save) begin
      if (cmd.job[0]) begin
        sq_q <= sq_r[30:0];
      end else begin
        sq_p <= sq_r[30:0];
      end
    end
    // result word
    if (cmd.commit) begin
      moved       <= first_r || dist_r >= thr;
      first_fix   <= first_r;
      distance_q8 <= dist_r;
    end
  end

`ifndef SYNTH
  a_first_moves: assert property (@(posedge clk) disable iff (rst)
    (cmd.commit && first_r) |=> (moved && first_fix && distance_q8 == '0))
    else $error("first fix not reported as move with zero distance");
  a_pos_kept: assert property (@(posedge clk) disable iff (rst)
    pos_valid |=> pos_valid)
    else $error("stored position lost");
  a_dist_sat: assert property (@(posedge clk) disable iff (rst)
    cmd.commit |-> dist_r <= DIST_MAX)
    else $error("distance beyond saturation limit");
`endif

endmodule

[hw/rtl/haversine_move_detector.sv]
// top level of the haversine move detector
// Each accepted fix (latitude, longitude in degrees, ANGLE_FRAC_BITS fraction bits)
// is compared with the last stored position by the haversine great-circle distance
// on a 6371 km sphere; one result word follows each fix. A first fix skips the
// computation: it is stored and its result word is reported without a distance run.
// Any later fix runs through one shared multiplier, one shared CORDIC unit and a
// one-bit-per-cycle square root, one fix at a time; most of the computation time is
// spent in the five CORDIC runs and the two 31-step square roots. A new fix may be
// taken while the previous result word still waits on the output. The threshold
// register may be written at any time while no fix is in flight.
module haversine_move_detector
  import hmd_pkg::*;
#(
  parameter int ANGLE_FRAC_BITS   = 20,
  parameter int CORDIC_ITERATIONS = 24
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [22:0]        cfg_data,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic signed [27:0] new_latitude,
  input  logic signed [28:0] new_longitude,
  output logic               out_valid,
  input  logic               out_ready,
  output logic               moved,
  output logic               first_fix,
  output logic [22:0]        distance_q8
);

  dp_cmd_t cmd;
  logic    pos_valid;

  // threshold writes always land
  assign cfg_ready = 1'b1;

  hmd_ctrl #(
    .ANGLE_FRAC_BITS  (ANGLE_FRAC_BITS),
    .CORDIC_ITERATIONS(CORDIC_ITERATIONS)
  ) u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .pos_valid(pos_valid),
    .cmd      (cmd)
  );

  hmd_datapath #(
    .ANGLE_FRAC_BITS(ANGLE_FRAC_BITS)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .cfg_valid    (cfg_valid),
    .cfg_data     (cfg_data),
    .new_latitude (new_latitude),
    .new_longitude(new_longitude),
    .pos_valid    (pos_valid),
    .moved        (moved),
    .first_fix    (first_fix),
    .distance_q8  (distance_q8)
  );

endmodule
